// ===== rtl/wal_record_checker_assert.svh =====
// ----------------------------------------------------------------------------
// wal_record_checker_assert
// assertion macros used by the checker file wrc_checker.sv
// ----------------------------------------------------------------------------
`ifndef WAL_RECORD_CHECKER_ASSERT_SVH
`define WAL_RECORD_CHECKER_ASSERT_SVH

// antecedent holds in the same cycle as the consequent
`define WRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define WRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrc_pkg
// shared types, constants and the crc byte function of the log record checker
// ----------------------------------------------------------------------------
package wrc_pkg;

    localparam int PAYLOAD_BYTES      = 96;
    localparam int PATH_ELEMENT_BYTES = 8;
    localparam int NEED_W             = 16;

    localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES  = 32'hFFFF_FFFF;
    localparam logic [31:0] MIN_TOTAL = 32'd10;
    localparam logic [31:0] CRC_TAIL  = 32'd8;
    localparam logic [7:0]  OP_INSERT = 8'd1;
    localparam logic [7:0]  OP_REMOVE = 8'd2;

    typedef logic [NEED_W-1:0] t_need;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_TRUNC  = 3'd2,
        ST_CRC    = 3'd3,
        ST_OPCODE = 3'd4,
        ST_EMPTY  = 3'd5,
        ST_SIZE   = 3'd6
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [7:0]  opcode;
        logic [7:0]  path_count;
        logic [31:0] record_bytes;
        logic [31:0] good_prefix_bytes;
        logic        stream_done;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== rtl/wrc_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrc_parser
// per-byte record state, crc update and verdict generation
// ----------------------------------------------------------------------------
module wrc_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_res_valid,
    output wrc_pkg::t_result o_res
);

    logic [31:0] r_pos, n_pos;
    logic [31:0] r_len, n_len;
    logic [31:0] r_crc, n_crc;
    logic [31:0] r_rcv, n_rcv;
    logic [7:0]  r_op, n_op;
    logic [7:0]  r_pc, n_pc;
    logic [31:0] r_acc, n_acc;
    logic        r_halt, n_halt;

    logic [31:0] w_idx;
    logic [31:0] w_body;
    logic [31:0] w_pos_inc;
    logic [31:0] w_tail_off;
    logic [32:0] w_sum;
    wrc_pkg::t_need w_need;
    wrc_pkg::t_status w_status;

    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_crc      = r_crc;
        n_rcv      = r_rcv;
        n_op       = r_op;
        n_pc       = r_pc;
        n_acc      = r_acc;
        n_halt     = r_halt;
        o_res_valid = 1'b0;
        o_res      = '0;
        w_status   = wrc_pkg::ST_OK;
        w_idx      = r_pos - 32'd4;
        w_body     = r_len - wrc_pkg::CRC_TAIL;
        w_pos_inc  = r_pos + 32'd1;
        w_tail_off = r_pos - r_len;
        w_sum      = {1'b0, r_acc} + {1'b0, r_len};
        w_need     = wrc_pkg::t_need'(2)
                   + wrc_pkg::t_need'(r_pc) * wrc_pkg::t_need'(wrc_pkg::PATH_ELEMENT_BYTES)
                   + ((r_op == wrc_pkg::OP_INSERT) ? wrc_pkg::t_need'(wrc_pkg::PAYLOAD_BYTES)
                                                    : wrc_pkg::t_need'(0));

        if (i_accept && !r_halt) begin
            n_pos = w_pos_inc;
            if (r_pos[31:2] == 30'd0) begin
                case (r_pos[1:0])
                    2'd0:    n_len[7:0]   = i_byte;
                    2'd1:    n_len[15:8]  = i_byte;
                    2'd2:    n_len[23:16] = i_byte;
                    default: n_len[31:24] = i_byte;
                endcase
                if (r_pos[1:0] == 2'd3 && n_len < wrc_pkg::MIN_TOTAL) begin
                    o_res_valid = 1'b1;
                    w_status    = wrc_pkg::ST_SHORT;
                    n_halt      = 1'b1;
                end else if (i_last) begin
                    o_res_valid = 1'b1;
                    w_status    = wrc_pkg::ST_TRUNC;
                end
            end else begin
                if (w_idx < w_body) begin
                    n_crc = wrc_pkg::crc_byte(r_crc, i_byte);
                    if (w_idx == 32'd0) begin
                        n_op = i_byte;
                    end else if (w_idx == 32'd1) begin
                        n_pc = i_byte;
                    end
                end else begin
                    case (w_tail_off[1:0])
                        2'd0:    n_rcv[7:0]   = i_byte;
                        2'd1:    n_rcv[15:8]  = i_byte;
                        2'd2:    n_rcv[23:16] = i_byte;
                        default: n_rcv[31:24] = i_byte;
                    endcase
                end
                if (w_pos_inc == r_len) begin
                    o_res_valid = 1'b1;
                    if ((r_crc ^ wrc_pkg::CRC_ONES) != n_rcv) begin
                        w_status = wrc_pkg::ST_CRC;
                    end else if (r_op != wrc_pkg::OP_INSERT && r_op != wrc_pkg::OP_REMOVE) begin
                        w_status = wrc_pkg::ST_OPCODE;
                    end else if (r_pc == 8'd0) begin
                        w_status = wrc_pkg::ST_EMPTY;
                    end else if (w_body != {{(32 - wrc_pkg::NEED_W){1'b0}}, w_need}) begin
                        w_status = wrc_pkg::ST_SIZE;
                    end else begin
                        w_status = wrc_pkg::ST_OK;
                    end
                    if (w_status == wrc_pkg::ST_OK) begin
                        n_acc = w_sum[32] ? 32'hFFFF_FFFF : w_sum[31:0];
                    end else begin
                        n_halt = 1'b1;
                    end
                end else if (i_last) begin
                    o_res_valid = 1'b1;
                    w_status    = wrc_pkg::ST_TRUNC;
                end
            end

            o_res.status            = w_status;
            o_res.opcode            = n_op;
            o_res.path_count        = n_pc;
            o_res.record_bytes      = n_len;
            o_res.good_prefix_bytes = n_acc;
            o_res.stream_done       = i_last;

            if (o_res_valid && w_status == wrc_pkg::ST_OK) begin
                n_pos = '0;
                n_len = '0;
                n_crc = wrc_pkg::CRC_ONES;
                n_rcv = '0;
                n_op  = '0;
                n_pc  = '0;
            end
        end

        if (i_accept && i_last) begin
            n_pos  = '0;
            n_len  = '0;
            n_crc  = wrc_pkg::CRC_ONES;
            n_rcv  = '0;
            n_op   = '0;
            n_pc   = '0;
            n_acc  = '0;
            n_halt = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_len  <= '0;
            r_crc  <= wrc_pkg::CRC_ONES;
            r_rcv  <= '0;
            r_op   <= '0;
            r_pc   <= '0;
            r_acc  <= '0;
            r_halt <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_len  <= n_len;
            r_crc  <= n_crc;
            r_rcv  <= n_rcv;
            r_op   <= n_op;
            r_pc   <= n_pc;
            r_acc  <= n_acc;
            r_halt <= n_halt;
        end
    end

endmodule

// ===== rtl/wrc_out_skid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrc_out_skid
// result register with a skid stage toward the output stream
// ----------------------------------------------------------------------------
module wrc_out_skid (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wrc_pkg::t_result i_res,
    output logic             o_room,
    output logic             o_valid,
    input  logic             i_ready,
    output wrc_pkg::t_result o_res
);

    logic             r_valid;
    logic             r_skid_valid;
    wrc_pkg::t_result r_res;
    wrc_pkg::t_result r_skid_res;

    assign o_room  = !r_skid_valid;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_valid && i_ready) begin
            if (r_skid_valid) begin
                r_res        <= r_skid_res;
                r_skid_valid <= 1'b0;
            end else if (i_push) begin
                r_res <= i_res;
            end else begin
                r_valid <= 1'b0;
            end
        end else if (i_push) begin
            if (!r_valid) begin
                r_res   <= i_res;
                r_valid <= 1'b1;
            end else begin
                r_skid_res   <= i_res;
                r_skid_valid <= 1'b1;
            end
        end
    end

endmodule

// ===== rtl/wal_record_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wal_record_checker
// byte-serial checker for length-prefixed, crc-32 protected log records
// ----------------------------------------------------------------------------
// usage
//   input stream: one log byte per request on s_axis tdata, tlast on the
//   final byte of the stream. output stream: at most one verdict per input
//   byte; tuser carries the status code, tdata the record fields, tlast is
//   set when the verdict came with the stream's final byte.
//   throughput: one byte per cycle while tready is high, limited by
//   the combinational crc byte update and the position/length compare
//   in the parser. a verdict for the byte that completes or ends the
//   record is registered in the result register, or skid entry if full.
//   after a bad verdict the block drops bytes until tlast, then restarts.
//   stall: a result register plus one skid entry absorb a stalled receiver;
//   s_axis tready drops only once both are occupied.
//   reset: synchronous, active low; record state, the good prefix count and
//   both output entries are emptied.
// ----------------------------------------------------------------------------
module wal_record_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // data_byte
    input  logic        i_s_axis_tlast,   // stream_last
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // opcode, path_count, record_bytes, good_prefix_bytes
    output logic [2:0]  o_m_axis_tuser,   // status
    output logic        o_m_axis_tlast    // stream_done
);

    logic             w_accept;
    logic             w_res_valid;
    logic             w_room;
    wrc_pkg::t_result w_res;
    wrc_pkg::t_result w_out;

    assign o_s_axis_tready = w_room;
    assign w_accept        = i_s_axis_tvalid && w_room;

    wrc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_byte      (i_s_axis_tdata),
        .i_last      (i_s_axis_tlast),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    wrc_out_skid u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_room  (w_room),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_res   (w_out)
    );

    assign o_m_axis_tdata = {w_out.good_prefix_bytes, w_out.record_bytes,
                             w_out.path_count, w_out.opcode};
    assign o_m_axis_tuser = w_out.status;
    assign o_m_axis_tlast = w_out.stream_done;

endmodule

// ===== rtl/wrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrc_checker
// port-level checks of the log record checker, bound to the top level
// ----------------------------------------------------------------------------
`include "wal_record_checker_assert.svh"

module wrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [79:0] o_m_axis_tdata,
    input logic [2:0]  o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    `WRC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast), "stalled request changed")
    `WRC_ASSERT_SAME(a_full_when_blocked, i_clk, i_rst_n, !o_s_axis_tready, o_m_axis_tvalid, "input blocked with empty output")
    `WRC_ASSERT_SAME(a_status_range, i_clk, i_rst_n, o_m_axis_tvalid, o_m_axis_tuser <= wrc_pkg::ST_SIZE, "status code out of range")
    `WRC_ASSERT_SAME(a_ok_prefix, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser == wrc_pkg::ST_OK, o_m_axis_tdata[79:48] >= o_m_axis_tdata[47:16], "good prefix below record length")
    `WRC_ASSERT_SAME(a_body_floor, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser >= wrc_pkg::ST_CRC, o_m_axis_tdata[47:16] >= wrc_pkg::MIN_TOTAL, "body verdict on a short record")

endmodule

bind wal_record_checker wrc_checker u_wrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
